// ----- rtl/core/hybrid_task_scheduler_macros.svh -----
`ifndef HYBRID_TASK_SCHEDULER_MACROS_SVH
`define HYBRID_TASK_SCHEDULER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle implies a condition in the next cycle.
`define HTS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/hts_pkg.sv -----
package hts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_IW    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_RUN      = 2'd2,
    KIND_PASS_END = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DEL_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_SINGLE   = 2'd1,
    ST_WALK     = 2'd2,
    ST_PASS_END = 2'd3
  } hts_state_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [2:0]  slot_index;
    logic [7:0]  task_tag;
    logic [15:0] start_delay;
    logic [15:0] period;
    logic        cooperative;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [3:0]   result_slot;
    logic [7:0]   result_tag;
    status_e      status;
    status_e      last_error;
    logic         last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic do_single;
    logic walk_step;
    logic pass_end;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic walk_emit;
    logic ptr_last;
  } dp_sts_t;

endpackage

// ----- rtl/core/hybrid_task_scheduler.sv -----
// Add and delete: request registered, then result registered once the output is free; the next request waits for it.
// Tick and dispatch: one slot per cycle over the TASK_SLOTS slots, then the pass-end result;
// each slot walk step waits while a run result is stalled.
// The slot walk of the controller sets this rate: one table entry is read and written per cycle.
// Reset clears the slot-used bits, the error code, the controller, the walk pointer and the output valid flag.
module hybrid_task_scheduler import hts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .sts_i         (sts),
    .in_stall_o    (in_stall_o),
    .cmd_o         (cmd)
  );

  hts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/hts_ctrl.sv -----
`include "hybrid_task_scheduler_macros.svh"

module hts_ctrl import hts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  req_type_e in_req_type_i,
  input  dp_sts_t   sts_i,
  output logic      in_stall_o,
  output dp_cmd_t   cmd_o
);

  hts_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_type_i == REQ_ADD || in_req_type_i == REQ_DELETE) begin
            state_d = ST_SINGLE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_SINGLE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if ((!sts_i.walk_emit || sts_i.out_free) && sts_i.ptr_last) begin
          state_d = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ST_SINGLE:   cmd_o.do_single = sts_i.out_free;
      // hold on a slot that runs until the output register can take it
      ST_WALK:     cmd_o.walk_step = !sts_i.walk_emit || sts_i.out_free;
      ST_PASS_END: cmd_o.pass_end  = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HTS_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o,
                   "request accepted but input not stalled in the next cycle")
  `HTS_ASSERT_NEXT(a_walk_to_end, cmd_o.walk_step && sts_i.ptr_last,
                   state_q == ST_PASS_END, "last slot walked without pass end")
  `HTS_ASSERT_NEXT(a_end_to_idle, cmd_o.pass_end || cmd_o.do_single, !in_stall_o,
                   "request finished but controller not back to idle")

endmodule

// ----- rtl/core/hts_dp.sv -----
`include "hybrid_task_scheduler_macros.svh"

module hts_dp import hts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  input  logic      out_stall_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  in_item_t               req_q;
  logic [SLOT_IW-1:0]     ptr_q;
  logic [TASK_SLOTS-1:0]  used_q;
  status_e                err_q, err_d;
  out_item_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic [7:0]  tag_q     [TASK_SLOTS];
  logic [15:0] delay_q   [TASK_SLOTS];
  logic [15:0] period_q  [TASK_SLOTS];
  logic [7:0]  pending_q [TASK_SLOTS];
  logic        coop_q    [TASK_SLOTS];

  logic [SLOT_IW-1:0] free_idx;
  logic               full;
  logic [SLOT_IW-1:0] del_idx;
  logic               del_beyond;
  logic               del_empty;
  out_item_t          single_res;

  logic        cur_used;
  logic [7:0]  cur_tag;
  logic [15:0] cur_delay;
  logic [15:0] cur_period;
  logic [7:0]  cur_pend;
  logic        cur_coop;
  logic        w_emit;
  logic        w_used;
  logic [15:0] w_delay;
  logic [7:0]  w_pend;
  logic        load_out;
  logic        add_write;

  // lowest empty slot
  always_comb begin
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SLOT_IW'(i);
      end
    end
  end

  assign full       = &used_q;
  assign del_beyond = int'(req_q.slot_index) >= TASK_SLOTS;
  assign del_idx    = SLOT_IW'(req_q.slot_index);
  assign del_empty  = del_beyond || !used_q[del_idx];
  assign add_write  = cmd_i.do_single && (req_q.req_type == REQ_ADD) && !full;

  always_comb begin
    err_d      = err_q;
    single_res = '0;
    if (req_q.req_type == REQ_ADD) begin
      if (full) begin
        err_d = STAT_FULL;
      end
      single_res.result_kind = KIND_ADD;
      single_res.result_slot = full ? 4'(TASK_SLOTS) : 4'(free_idx);
      single_res.status      = full ? STAT_FULL : STAT_OK;
    end else begin
      if (del_empty) begin
        err_d = STAT_DEL_EMPTY;
      end
      single_res.result_kind = KIND_DELETE;
      single_res.result_slot = 4'(req_q.slot_index);
      single_res.status      = del_empty ? STAT_DEL_EMPTY : STAT_OK;
    end
    single_res.result_tag = '0;
    single_res.last_error = err_d;
    single_res.last       = 1'b1;
  end

  assign cur_used   = used_q[ptr_q];
  assign cur_tag    = tag_q[ptr_q];
  assign cur_delay  = delay_q[ptr_q];
  assign cur_period = period_q[ptr_q];
  assign cur_pend   = pending_q[ptr_q];
  assign cur_coop   = coop_q[ptr_q];

  // one slot of a tick or dispatch pass
  always_comb begin
    w_emit  = 1'b0;
    w_used  = cur_used;
    w_delay = cur_delay;
    w_pend  = cur_pend;
    case (req_q.req_type)
      REQ_TICK: begin
        if (cur_used) begin
          if (cur_delay == 16'd0) begin
            if (cur_coop) begin
              if (cur_pend != 8'hFF) begin
                w_pend = cur_pend + 8'd1;
              end
            end else begin
              w_emit = 1'b1;
              if (cur_pend != 8'd0) begin
                w_pend = cur_pend - 8'd1;
              end
              if (cur_period == 16'd0) begin
                w_used = 1'b0;
              end
            end
            if (cur_period != 16'd0) begin
              w_delay = cur_period;
            end
          end else begin
            w_delay = cur_delay - 16'd1;
          end
        end
      end
      REQ_DISPATCH: begin
        if (cur_used && cur_coop && cur_pend != 8'd0) begin
          w_emit = 1'b1;
          w_pend = cur_pend - 8'd1;
          if (cur_period == 16'd0) begin
            w_used = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d    = out_q;
    load_out = 1'b0;
    if (cmd_i.do_single) begin
      out_d    = single_res;
      load_out = 1'b1;
    end else if (cmd_i.walk_step && w_emit) begin
      out_d.result_kind = KIND_RUN;
      out_d.result_slot = 4'(ptr_q);
      out_d.result_tag  = cur_tag;
      out_d.status      = STAT_OK;
      out_d.last_error  = err_q;
      out_d.last        = 1'b0;
      load_out          = 1'b1;
    end else if (cmd_i.pass_end) begin
      out_d.result_kind = KIND_PASS_END;
      out_d.result_slot = '0;
      out_d.result_tag  = '0;
      out_d.status      = STAT_OK;
      out_d.last_error  = err_q;
      out_d.last        = 1'b1;
      load_out          = 1'b1;
    end
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.walk_emit = w_emit;
  assign sts_o.ptr_last  = (ptr_q == SLOT_IW'(TASK_SLOTS - 1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      err_q       <= STAT_OK;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.do_single) begin
        err_q <= err_d;
      end
      if (add_write) begin
        used_q[free_idx] <= (req_q.task_tag != 8'd0);
      end else if (cmd_i.do_single && (req_q.req_type == REQ_DELETE) && !del_beyond) begin
        used_q[del_idx] <= 1'b0;
      end else if (cmd_i.walk_step) begin
        used_q[ptr_q] <= w_used;
      end
      if (cmd_i.load_req) begin
        ptr_q <= '0;
      end else if (cmd_i.walk_step) begin
        ptr_q <= sts_o.ptr_last ? '0 : ptr_q + SLOT_IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
    if (add_write) begin
      tag_q[free_idx]     <= req_q.task_tag;
      delay_q[free_idx]   <= req_q.start_delay;
      period_q[free_idx]  <= req_q.period;
      pending_q[free_idx] <= 8'd0;
      coop_q[free_idx]    <= req_q.cooperative;
    end else if (cmd_i.walk_step) begin
      delay_q[ptr_q]   <= w_delay;
      pending_q[ptr_q] <= w_pend;
    end
  end

  `HTS_ASSERT(a_load_free, load_out |-> sts_o.out_free,
              "result written over an untaken result")
  `HTS_ASSERT_NEXT(a_ptr_advance, cmd_i.walk_step && !sts_o.ptr_last && !cmd_i.load_req,
                   ptr_q == $past(ptr_q) + SLOT_IW'(1), "walk pointer did not advance")
  `HTS_ASSERT_NEXT(a_full_keeps, add_write == 1'b0 && cmd_i.do_single &&
                   req_q.req_type == REQ_ADD, $stable(used_q),
                   "add on a full table changed the table")

endmodule
